@@ rtl/m3i_pkg.sv @@
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants for the 3x3 matrix inverse
// Cofactor index tables, lane count and the control word that travels
// alongside the lane datapath.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int unsigned LANES = 9;
  localparam int unsigned EPS_W = 31;
  localparam logic [EPS_W-1:0] EPS_RESET = 31'd1;

  typedef int unsigned idx_arr_t [LANES];

  // cofactor i = a[MP]*a[MQ] - a[MR]*a[MS], negated where ADJ_NEG is set
  localparam idx_arr_t MP = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam idx_arr_t MQ = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
  localparam idx_arr_t MR = '{7, 2, 2, 5, 2, 3, 6, 6, 3};
  localparam idx_arr_t MS = '{5, 7, 4, 6, 6, 2, 4, 1, 1};
  localparam logic [LANES-1:0] ADJ_NEG = 9'b010101010;

  // determinant expands along row 0 with cofactors 0, 3 and 6
  typedef int unsigned col_arr_t [3];
  localparam col_arr_t DET_COL = '{0, 3, 6};

  typedef struct packed {
    logic valid;
    logic singular;
  } m3i_ctl_t;

endpackage

@@ rtl/m3i_in_if.sv @@
// ----------------------------------------------------------------------------
// m3i_in_if: input channel carrying one 3x3 matrix
// Valid/ready handshake with the nine elements in row-major order.
// ----------------------------------------------------------------------------
interface m3i_in_if #(
  parameter int unsigned W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a00, a01, a02;
  logic signed [W-1:0] a10, a11, a12;
  logic signed [W-1:0] a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

@@ rtl/m3i_out_if.sv @@
// ----------------------------------------------------------------------------
// m3i_out_if: output channel carrying one inverted matrix
// Valid/ready handshake with nine elements and two status flags.
// ----------------------------------------------------------------------------
interface m3i_out_if #(
  parameter int unsigned W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] b00, b01, b02;
  logic signed [W-1:0] b10, b11, b12;
  logic signed [W-1:0] b20, b21, b22;
  logic                invertible;
  logic                saturated;

  modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                  invertible, saturated, input ready);
  modport sink   (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                  invertible, saturated, output ready);
endinterface

@@ rtl/m3i_adj.sv @@
// ----------------------------------------------------------------------------
// m3i_adj: adjugate and determinant pipeline
// Five stages: minor products, cofactors, split determinant products,
// determinant sum with magnitude, rounded singularity test.
// ----------------------------------------------------------------------------
module m3i_adj import m3i_pkg::*; #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [W-1:0]       a_i [LANES],
  input  logic [EPS_W-1:0]          eps_i,
  output m3i_ctl_t                  ctl_o,
  output logic signed [W-1:0]       a_o [LANES],
  output logic signed [2*W:0]       adj_o [LANES],
  output logic [3*W+2:0]            mag_o,
  output logic                      det_neg_o
);
  localparam int unsigned AW  = 2 * W + 1;
  localparam int unsigned DW  = 3 * W + 3;
  localparam int unsigned RDW = DW + 1 - 2 * F;
  localparam int unsigned CW  = (RDW > EPS_W) ? RDW : EPS_W;

  logic [3:0]            v_q;
  m3i_ctl_t              ctl_q;

  logic signed [2*W-1:0] pp_q [LANES];
  logic signed [2*W-1:0] pq_q [LANES];
  logic signed [W-1:0]   a1_q [LANES];
  logic signed [AW-1:0]  adj2_q [LANES];
  logic signed [W-1:0]   a2_q [LANES];
  logic signed [2*W:0]   lo3_q [3];
  logic signed [2*W:0]   hi3_q [3];
  logic signed [AW-1:0]  adj3_q [LANES];
  logic signed [W-1:0]   a3_q [LANES];
  logic [DW-1:0]         mag4_q;
  logic                  neg4_q;
  logic signed [AW-1:0]  adj4_q [LANES];
  logic signed [W-1:0]   a4_q [LANES];
  logic [DW-1:0]         mag5_q;
  logic                  neg5_q;
  logic signed [AW-1:0]  adj5_q [LANES];
  logic signed [W-1:0]   a5_q [LANES];

  logic signed [DW-1:0]  det_d;
  logic [DW:0]           rnd_full;
  logic [CW-1:0]         rnd_ext;
  logic [CW-1:0]         eps_ext;

  always_comb begin
    det_d = '0;
    for (int k = 0; k < 3; k++) begin
      det_d = det_d + (DW'(hi3_q[k]) <<< W) + DW'(lo3_q[k]);
    end
  end

  // half away from zero on the magnitude, then drop 2F fraction bits
  assign rnd_full = {1'b0, mag4_q} + ((DW + 1)'(1) << (2 * F - 1));
  assign rnd_ext  = CW'(rnd_full[DW:2*F]);
  assign eps_ext  = CW'(eps_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      ctl_q <= '0;
    end else if (en_i) begin
      v_q            <= {v_q[2:0], valid_i};
      ctl_q.valid    <= v_q[3];
      ctl_q.singular <= (rnd_ext <= eps_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < LANES; i++) begin
        pp_q[i] <= a_i[MP[i]] * a_i[MQ[i]];
        pq_q[i] <= a_i[MR[i]] * a_i[MS[i]];
        a1_q[i] <= a_i[i];
        adj2_q[i] <= ADJ_NEG[i] ? (AW'(pq_q[i]) - AW'(pp_q[i]))
                                : (AW'(pp_q[i]) - AW'(pq_q[i]));
        a2_q[i]   <= a1_q[i];
        adj3_q[i] <= adj2_q[i];
        a3_q[i]   <= a2_q[i];
        adj4_q[i] <= adj3_q[i];
        a4_q[i]   <= a3_q[i];
        adj5_q[i] <= adj4_q[i];
        a5_q[i]   <= a4_q[i];
      end
      for (int k = 0; k < 3; k++) begin
        lo3_q[k] <= a2_q[k] * $signed({1'b0, adj2_q[DET_COL[k]][W-1:0]});
        hi3_q[k] <= a2_q[k] * $signed(adj2_q[DET_COL[k]][AW-1:W]);
      end
      neg4_q <= det_d[DW-1];
      mag4_q <= det_d[DW-1] ? DW'(-det_d) : DW'(det_d);
      neg5_q <= neg4_q;
      mag5_q <= mag4_q;
    end
  end

  assign ctl_o     = ctl_q;
  assign a_o       = a5_q;
  assign adj_o     = adj5_q;
  assign mag_o     = mag5_q;
  assign det_neg_o = neg5_q;

endmodule

@@ rtl/m3i_div_lane.sv @@
// ----------------------------------------------------------------------------
// m3i_div_lane: one lane of the inverse, cofactor over determinant
// Restoring division, one quotient bit per stage, followed by sign, clip
// and the singular pass-through select.
// ----------------------------------------------------------------------------
module m3i_div_lane import m3i_pkg::*; #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [2*W:0]   adj_i,
  input  logic [3*W+2:0]        mag_i,
  input  logic                  det_neg_i,
  input  logic                  singular_i,
  input  logic signed [W-1:0]   a_i,
  output logic signed [W-1:0]   b_o,
  output logic                  sat_o
);
  localparam int unsigned AW = 2 * W + 1;
  localparam int unsigned DW = 3 * W + 3;
  localparam int unsigned QB = W + 1;
  localparam int unsigned RW = DW + QB;
  localparam logic [QB-1:0] LIM_POS = {{(QB - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic [QB-1:0] LIM_NEG = {{(QB - W){1'b0}}, 1'b1, {(W - 1){1'b0}}};

  logic [RW-1:0]       rem_q  [QB+1];
  logic [QB-1:0]       qt_q   [QB+1];
  logic [DW-1:0]       mag_q  [QB+1];
  logic                neg_q  [QB+1];
  logic                ovf_q  [QB+1];
  logic                sing_q [QB+1];
  logic signed [W-1:0] a_q    [QB+1];
  logic signed [W-1:0] b_q;
  logic                sat_q;

  logic [AW-1:0]       abs_adj;
  logic [RW-1:0]       num;
  logic                clip;
  logic [QB-1:0]       qlim;
  logic [QB-1:0]       qmag;
  logic [QB-1:0]       qres;

  assign abs_adj = adj_i[AW-1] ? AW'(-adj_i) : AW'(adj_i);
  assign num     = RW'(abs_adj) << (2 * F);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num;
      qt_q[0]   <= '0;
      mag_q[0]  <= mag_i;
      neg_q[0]  <= adj_i[AW-1] ^ det_neg_i;
      // quotient of 2^(W+1) or more cannot fit whatever the sign
      ovf_q[0]  <= num >= (RW'(mag_i) << QB);
      sing_q[0] <= singular_i;
      a_q[0]    <= a_i;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int unsigned K = QB - 1 - j;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(mag_q[j]) << K;
    assign ge  = rem_q[j] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= ge ? rem_q[j] - dsh : rem_q[j];
        qt_q[j+1]   <= {qt_q[j][QB-2:0], ge};
        mag_q[j+1]  <= mag_q[j];
        neg_q[j+1]  <= neg_q[j];
        ovf_q[j+1]  <= ovf_q[j];
        sing_q[j+1] <= sing_q[j];
        a_q[j+1]    <= a_q[j];
      end
    end
  end

  assign qlim = neg_q[QB] ? LIM_NEG : LIM_POS;
  assign clip = ovf_q[QB] || (qt_q[QB] > qlim);
  assign qmag = clip ? qlim : qt_q[QB];
  assign qres = neg_q[QB] ? (QB'(0) - qmag) : qmag;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q   <= sing_q[QB] ? a_q[QB] : $signed(qres[W-1:0]);
      sat_q <= !sing_q[QB] && clip;
    end
  end

  assign b_o   = b_q;
  assign sat_o = sat_q;

endmodule

@@ rtl/m3i_merge.sv @@
// ----------------------------------------------------------------------------
// m3i_merge: lane merge and output stage
// Aligns the control word with the lanes, combines the lane flags, and
// drives the output through a register with a one-item skid buffer.
// ----------------------------------------------------------------------------
module m3i_merge import m3i_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  m3i_ctl_t            ctl_i,
  input  logic signed [W-1:0] b_i [LANES],
  input  logic [LANES-1:0]    sat_i,
  output logic                en_o,
  m3i_out_if.source           out_o
);
  localparam int unsigned DLY = W + 3;

  m3i_ctl_t            ctl_q [DLY];
  logic                out_v_q;
  logic                skid_v_q;
  logic signed [W-1:0] out_b_q [LANES];
  logic                out_inv_q;
  logic                out_sat_q;
  logic signed [W-1:0] skid_b_q [LANES];
  logic                skid_inv_q;
  logic                skid_sat_q;

  logic                pipe_v;
  logic                pipe_inv;
  logic                pipe_sat;

  assign en_o     = !skid_v_q;
  assign pipe_v   = ctl_q[DLY-1].valid;
  assign pipe_inv = !ctl_q[DLY-1].singular;
  assign pipe_sat = |sat_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DLY; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en_o) begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < DLY; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && out_o.ready) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= pipe_v;
      end
    end else if (!out_v_q) begin
      out_v_q <= pipe_v;
    end else if (pipe_v && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && out_o.ready && skid_v_q) begin
      out_b_q   <= skid_b_q;
      out_inv_q <= skid_inv_q;
      out_sat_q <= skid_sat_q;
    end else if ((!out_v_q || out_o.ready) && pipe_v) begin
      out_b_q   <= b_i;
      out_inv_q <= pipe_inv;
      out_sat_q <= pipe_sat;
    end
    if (out_v_q && !out_o.ready && !skid_v_q && pipe_v) begin
      skid_b_q   <= b_i;
      skid_inv_q <= pipe_inv;
      skid_sat_q <= pipe_sat;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.b00        = out_b_q[0];
  assign out_o.b01        = out_b_q[1];
  assign out_o.b02        = out_b_q[2];
  assign out_o.b10        = out_b_q[3];
  assign out_o.b11        = out_b_q[4];
  assign out_o.b12        = out_b_q[5];
  assign out_o.b20        = out_b_q[6];
  assign out_o.b21        = out_b_q[7];
  assign out_o.b22        = out_b_q[8];
  assign out_o.invertible = out_inv_q;
  assign out_o.saturated  = out_sat_q;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds an item while output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_o.ready && skid_v_q |=> out_v_q && !skid_v_q)
    else $error("skid item not moved to output register");

  a_singular_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_inv_q |-> !out_sat_q)
    else $error("saturated set on a pass-through item");
`endif

endmodule

@@ rtl/matrix3x3_inverse.sv @@
// ----------------------------------------------------------------------------
// matrix3x3_inverse: 3x3 fixed-point matrix inverse by adjugate
// Usage:
//   in_i takes one matrix per item (a00..a22, row-major, signed fixed point).
//   out_o gives the inverse (b00..b22) with invertible and saturated flags;
//   a matrix whose rounded |det| is at or below singular_epsilon comes back
//   unchanged with invertible low.
//   cfg_we_i/cfg_wdata_i write singular_epsilon; write only while idle.
// Timing:
//   From accept to out valid an item passes five cofactor/determinant
//   stages, one divider setup stage, ELEMENT_WIDTH + 1 quotient-bit stages
//   in each of nine parallel lanes, a clip stage and the output register.
//   Throughput is one item per cycle while out_o does not stall; the
//   quotient-bit stages set latency.
// Reset clears all valid state and sets singular_epsilon to 1.
// When out_o stalls, one more item lands in a skid register; after that the
// whole pipeline holds and in_i.ready drops until the output drains.
// ----------------------------------------------------------------------------
module matrix3x3_inverse import m3i_pkg::*; #(
  parameter int unsigned ELEMENT_WIDTH = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [EPS_W-1:0] cfg_wdata_i,
  m3i_in_if.sink           in_i,
  m3i_out_if.source        out_o
);
  localparam int unsigned W = ELEMENT_WIDTH;
  localparam int unsigned F = FRACTION_BITS;

  logic [EPS_W-1:0]    eps_q;
  logic                en;
  logic signed [W-1:0] a_in [LANES];
  m3i_ctl_t            ctl;
  logic signed [W-1:0] a_s [LANES];
  logic signed [2*W:0] adj_s [LANES];
  logic [3*W+2:0]      mag_s;
  logic                det_neg_s;
  logic signed [W-1:0] b_l [LANES];
  logic [LANES-1:0]    sat_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = en;
  assign a_in[0] = in_i.a00;
  assign a_in[1] = in_i.a01;
  assign a_in[2] = in_i.a02;
  assign a_in[3] = in_i.a10;
  assign a_in[4] = in_i.a11;
  assign a_in[5] = in_i.a12;
  assign a_in[6] = in_i.a20;
  assign a_in[7] = in_i.a21;
  assign a_in[8] = in_i.a22;

  m3i_adj #(.W(W), .F(F)) u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_i.valid),
    .a_i       (a_in),
    .eps_i     (eps_q),
    .ctl_o     (ctl),
    .a_o       (a_s),
    .adj_o     (adj_s),
    .mag_o     (mag_s),
    .det_neg_o (det_neg_s)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    m3i_div_lane #(.W(W), .F(F)) u_lane (
      .clk_i      (clk_i),
      .en_i       (en),
      .adj_i      (adj_s[i]),
      .mag_i      (mag_s),
      .det_neg_i  (det_neg_s),
      .singular_i (ctl.singular),
      .a_i        (a_s[i]),
      .b_o        (b_l[i]),
      .sat_o      (sat_l[i])
    );
  end

  m3i_merge #(.W(W)) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .b_i    (b_l),
    .sat_i  (sat_l),
    .en_o   (en),
    .out_o  (out_o)
  );

endmodule
